### src/terrain_aspect_3x3_defines.svh
// assertion macros for the terrain aspect block
// used by the port checker; needs clk and arst_n in scope
`ifndef TERRAIN_ASPECT_3X3_DEFINES_SVH
`define TERRAIN_ASPECT_3X3_DEFINES_SVH

// clocked check, off while reset is asserted
`define TA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define TA_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tasp_pkg.sv
// shared types, widths and constants of the terrain aspect pipeline
// no dependencies
package tasp_pkg;

	localparam int ELEV_W   = 24;
	localparam int RES_W    = 16;
	localparam int GRAD_W   = 27;
	localparam int PROD_W   = 44;
	localparam int V_W      = 48;
	localparam int Z_W      = 28;
	localparam int ATAN_W   = 27;
	localparam int THETA_W  = 30;
	localparam int ASPECT_W = 13;
	localparam int ATAN_N   = 24;

	// normalized vector has its top bit here
	localparam int NORM_TOP = 44;

	// angles in 2^-20 degree
	localparam logic [ATAN_W-1:0]  DEG90     = 27'd94371840;
	localparam logic [THETA_W-1:0] DEG180    = 30'd188743680;
	localparam logic [THETA_W-1:0] DEG360    = 30'd377487360;
	localparam logic [THETA_W-1:0] ROUND_HALF = 30'd32768;

	// aspect codes in 1/16 degree
	localparam logic [ASPECT_W-1:0] ASP_ZERO = 13'd0;
	localparam logic [ASPECT_W-1:0] ASP_90   = 13'd1440;
	localparam logic [ASPECT_W-1:0] ASP_180  = 13'd2880;
	localparam logic [ASPECT_W-1:0] ASP_270  = 13'd4320;
	localparam logic [ASPECT_W:0]   ASP_FULL = 14'd5760;

	// atan(2^-i) in 2^-20 degree, rounded to nearest
	localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
		27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
		27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
		27'd234682,   27'd117342,   27'd58671,    27'd29335,
		27'd14668,    27'd7334,     27'd3667,     27'd1833,
		27'd917,      27'd458,      27'd229,      27'd115,
		27'd57,       27'd29,       27'd14,       27'd7
	};

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_EW_RES  = 2'd0,
		REG_NS_RES  = 2'd1,
		REG_UPSLOPE = 2'd2
	} cfg_reg_t;

	// one 3x3 window without its center
	typedef struct packed {
		logic signed [ELEV_W-1:0] nw;
		logic signed [ELEV_W-1:0] n;
		logic signed [ELEV_W-1:0] ne;
		logic signed [ELEV_W-1:0] w;
		logic signed [ELEV_W-1:0] e;
		logic signed [ELEV_W-1:0] sw;
		logic signed [ELEV_W-1:0] s;
		logic signed [ELEV_W-1:0] se;
	} elev_win_t;

	// sign and zero status of the scaled gradients
	typedef struct packed {
		logic xz;
		logic yz;
		logic xneg;
		logic yneg;
	} quad_t;

	// vector handed from cell to cell
	typedef struct packed {
		logic signed [V_W-1:0] x;
		logic signed [V_W-1:0] y;
		logic signed [Z_W-1:0] z;
		quad_t                 q;
	} vec_t;

endpackage

### src/tasp_front.sv
// gradient, resolution scaling and magnitude stages
// depends on tasp_pkg
module tasp_front import tasp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [RES_W-1:0] ew_res,
	input  logic [RES_W-1:0] ns_res,
	input  logic             valid_in,
	input  elev_win_t        win,
	input  logic             go_next,
	output logic             go,
	output logic             valid_out,
	output vec_t             vec_out
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [GRAD_W-1:0] gx_s1, gy_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	vec_t                     vec_s3;
	logic                     go1, go2, go3;
	logic signed [GRAD_W-1:0] nw, n, ne, w, e, sw, s, se;
	logic signed [GRAD_W-1:0] gx, gy;
	logic signed [PROD_W-1:0] px, py;
	logic [PROD_W-1:0]        ax, ay;
	vec_t                     vec_d;

	// stage moves when empty or when the next one moves
	assign go3 = !valid_s3 || go_next;
	assign go2 = !valid_s2 || go3;
	assign go1 = !valid_s1 || go2;
	assign go  = go1;

	// horn weights 1,2,1
	always_comb begin
		nw = GRAD_W'(win.nw);
		n  = GRAD_W'(win.n);
		ne = GRAD_W'(win.ne);
		w  = GRAD_W'(win.w);
		e  = GRAD_W'(win.e);
		sw = GRAD_W'(win.sw);
		s  = GRAD_W'(win.s);
		se = GRAD_W'(win.se);
		gx = (nw + (w <<< 1) + sw) - (ne + (e <<< 1) + se);
		gy = (sw + (s <<< 1) + se) - (nw + (n <<< 1) + ne);
	end

	// cross-multiply by the other axis resolution
	assign px = $signed({{(PROD_W-GRAD_W){gx_s1[GRAD_W-1]}}, gx_s1})
		* $signed({{(PROD_W-RES_W){1'b0}}, ns_res});
	assign py = $signed({{(PROD_W-GRAD_W){gy_s1[GRAD_W-1]}}, gy_s1})
		* $signed({{(PROD_W-RES_W){1'b0}}, ew_res});

	// magnitudes and quadrant flags
	always_comb begin
		ax = px_s2[PROD_W-1] ? PROD_W'(-px_s2) : PROD_W'(px_s2);
		ay = py_s2[PROD_W-1] ? PROD_W'(-py_s2) : PROD_W'(py_s2);
		vec_d.x      = $signed({{(V_W-PROD_W){1'b0}}, ay});
		vec_d.y      = $signed({{(V_W-PROD_W){1'b0}}, ax});
		vec_d.z      = '0;
		vec_d.q.xz   = (px_s2 == '0);
		vec_d.q.yz   = (py_s2 == '0);
		vec_d.q.xneg = px_s2[PROD_W-1];
		vec_d.q.yneg = py_s2[PROD_W-1];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (go1) valid_s1 <= valid_in;
			if (go2) valid_s2 <= valid_s1;
			if (go3) valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (go1) begin
			gx_s1 <= gx;
			gy_s1 <= gy;
		end
		if (go2) begin
			px_s2 <= px;
			py_s2 <= py;
		end
		if (go3) vec_s3 <= vec_d;
	end

	assign valid_out = valid_s3;
	assign vec_out   = vec_s3;

endmodule

### src/tasp_norm_cell.sv
// one step of the normalizing shift: shifts both components left when
// the SHIFT bits from NORM_TOP down are clear; depends on tasp_pkg
module tasp_norm_cell import tasp_pkg::*; #(
	parameter int SHIFT = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	input  vec_t vec_in,
	input  logic go_next,
	output logic go,
	output logic valid_out,
	output vec_t vec_out
);

	logic             valid_s1;
	vec_t             vec_s1;
	logic [V_W-1:0]   both;
	vec_t             vec_d;

	assign go = !valid_s1 || go_next;

	// the larger component decides the shift
	always_comb begin
		both  = vec_in.x | vec_in.y;
		vec_d = vec_in;
		if (both[NORM_TOP -: SHIFT] == '0) begin
			vec_d.x = vec_in.x <<< SHIFT;
			vec_d.y = vec_in.y <<< SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (go) vec_s1 <= vec_d;
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule

### src/tasp_cordic_cell.sv
// one cordic vectoring rotation with its own atan constant
// depends on tasp_pkg
module tasp_cordic_cell import tasp_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	input  vec_t vec_in,
	input  logic go_next,
	output logic go,
	output logic valid_out,
	output vec_t vec_out
);

	logic                  valid_s1;
	vec_t                  vec_s1;
	logic signed [V_W-1:0] xs, ys;
	logic signed [Z_W-1:0] da;
	vec_t                  vec_d;

	assign go = !valid_s1 || go_next;

	// rotate toward the x axis, floor shifts
	always_comb begin
		xs    = vec_in.x >>> IDX;
		ys    = vec_in.y >>> IDX;
		da    = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TAB[IDX]});
		vec_d = vec_in;
		if (!vec_in.y[V_W-1]) begin
			vec_d.x = vec_in.x + ys;
			vec_d.y = vec_in.y - xs;
			vec_d.z = vec_in.z + da;
		end else begin
			vec_d.x = vec_in.x - ys;
			vec_d.y = vec_in.y + xs;
			vec_d.z = vec_in.z - da;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (go) vec_s1 <= vec_d;
	end

	assign valid_out = valid_s1;
	assign vec_out   = vec_s1;

endmodule

### src/tasp_back.sv
// quadrant mapping, rounding and special cases; holds the output register
// depends on tasp_pkg
module tasp_back import tasp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upslope,
	input  logic                valid_in,
	input  vec_t                vec_in,
	output logic                go,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [ASPECT_W-1:0] aspect,
	output logic                undefined
);

	logic                valid_s1, valid_s2;
	logic [THETA_W-1:0]  theta_s1;
	quad_t               quad_s1;
	logic [ASPECT_W-1:0] aspect_s2;
	logic                undef_s2;
	logic                go1, go2;
	logic [ATAN_W-1:0]   phi;
	logic [THETA_W-1:0]  phi_w, theta;
	logic [THETA_W-1:0]  rsum;
	logic [ASPECT_W:0]   rnd;
	logic [ASPECT_W:0]   rwrap;
	logic [ASPECT_W-1:0] asp_d;
	logic                undef_d;

	assign go2 = !valid_s2 || !out_stall;
	assign go1 = !valid_s1 || go2;
	assign go  = go1;

	// clamp to the first quadrant and map to the full circle
	always_comb begin
		if (vec_in.z[Z_W-1]) begin
			phi = '0;
		end else if (vec_in.z > $signed({{(Z_W-ATAN_W){1'b0}}, DEG90})) begin
			phi = DEG90;
		end else begin
			phi = vec_in.z[ATAN_W-1:0];
		end
		phi_w = {{(THETA_W-ATAN_W){1'b0}}, phi};
		case ({vec_in.q.yneg, vec_in.q.xneg})
			2'b00:   theta = phi_w;
			2'b10:   theta = DEG180 - phi_w;
			2'b11:   theta = DEG180 + phi_w;
			default: theta = DEG360 - phi_w;
		endcase
	end

	// round to 1/16 degree, wrap a full turn, pick the special cases
	always_comb begin
		rsum    = theta_s1 + ROUND_HALF;
		rnd     = rsum[THETA_W-1 -: (ASPECT_W+1)];
		rwrap   = (rnd >= ASP_FULL) ? (rnd - ASP_FULL) : rnd;
		undef_d = 1'b0;
		if (quad_s1.yz && quad_s1.xz) begin
			asp_d   = ASP_ZERO;
			undef_d = 1'b1;
		end else if (quad_s1.yz) begin
			asp_d = (quad_s1.xneg ^ upslope) ? ASP_270 : ASP_90;
		end else if (quad_s1.xz) begin
			asp_d = quad_s1.yneg ? ASP_180 : ASP_ZERO;
		end else begin
			asp_d = rwrap[ASPECT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (go1) valid_s1 <= valid_in;
			if (go2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			theta_s1 <= theta;
			quad_s1  <= vec_in.q;
		end
		if (go2) begin
			aspect_s2 <= asp_d;
			undef_s2  <= undef_d;
		end
	end

	assign out_valid = valid_s2;
	assign aspect    = aspect_s2;
	assign undefined = undef_s2;

endmodule

### src/terrain_aspect_3x3.sv
// terrain aspect of a 3x3 elevation window, top level
// depends on tasp_pkg, tasp_front, tasp_norm_cell, tasp_cordic_cell, tasp_back
//
// usage:
//  each request on the input channel (in_valid / in_stall) carries the eight
//  neighbors of one grid cell. the result channel (out_valid / out_stall)
//  returns the aspect in 1/16 degree and a flag for a flat window.
//  the cell sizes and the upslope mode are written on the cfg port while
//  no request is in flight.
//  one request enters per cycle while in_stall is low; the stages are
//  gradient, scaling and magnitude, the normalizing shift cells, the
//  cordic cells, then mapping and rounding.
//  every stage holds its own valid bit and moves when the stage after it
//  is empty or moving, so with out_stall high the requests close up behind
//  the waiting result and in_stall rises only once every stage is full.
//  reset empties all stages and sets both cell sizes to 1, upslope mode 0.
module terrain_aspect_3x3 import tasp_pkg::*; #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [RES_W-1:0]         cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ELEV_W-1:0] elev_nw,
	input  logic signed [ELEV_W-1:0] elev_n,
	input  logic signed [ELEV_W-1:0] elev_ne,
	input  logic signed [ELEV_W-1:0] elev_w,
	input  logic signed [ELEV_W-1:0] elev_e,
	input  logic signed [ELEV_W-1:0] elev_sw,
	input  logic signed [ELEV_W-1:0] elev_s,
	input  logic signed [ELEV_W-1:0] elev_se,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ASPECT_W-1:0]      aspect,
	output logic                     undefined
);

	localparam int NORM_STEPS = 6;

	logic [RES_W-1:0] ew_res_q, ns_res_q;
	logic             upslope_q;
	elev_win_t        win;
	logic             front_go;

	vec_t n_vec [NORM_STEPS+1];
	logic n_v   [NORM_STEPS+1];
	logic n_go  [NORM_STEPS+1];

	vec_t c_vec [ANGLE_ITERATIONS+1];
	logic c_v   [ANGLE_ITERATIONS+1];
	logic c_go  [ANGLE_ITERATIONS+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_res_q  <= RES_W'(1);
			ns_res_q  <= RES_W'(1);
			upslope_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_EW_RES:  ew_res_q  <= cfg_wdata;
				REG_NS_RES:  ns_res_q  <= cfg_wdata;
				REG_UPSLOPE: upslope_q <= cfg_wdata[0];
				default:     ;
			endcase
		end
	end

	assign win = '{nw: elev_nw, n: elev_n, ne: elev_ne, w: elev_w,
		e: elev_e, sw: elev_sw, s: elev_s, se: elev_se};

	tasp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ew_res    (ew_res_q),
		.ns_res    (ns_res_q),
		.valid_in  (in_valid),
		.win       (win),
		.go_next   (n_go[0]),
		.go        (front_go),
		.valid_out (n_v[0]),
		.vec_out   (n_vec[0])
	);

	assign in_stall = !front_go;

	// normalizing shift by 32, 16, 8, 4, 2, 1
	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		tasp_norm_cell #(
			.SHIFT (32 >> k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (n_v[k]),
			.vec_in    (n_vec[k]),
			.go_next   (n_go[k+1]),
			.go        (n_go[k]),
			.valid_out (n_v[k+1]),
			.vec_out   (n_vec[k+1])
		);
	end

	assign c_vec[0]          = n_vec[NORM_STEPS];
	assign c_v[0]            = n_v[NORM_STEPS];
	assign n_go[NORM_STEPS]  = c_go[0];

	// cordic rotation chain
	for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
		tasp_cordic_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (c_v[i]),
			.vec_in    (c_vec[i]),
			.go_next   (c_go[i+1]),
			.go        (c_go[i]),
			.valid_out (c_v[i+1]),
			.vec_out   (c_vec[i+1])
		);
	end

	tasp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.upslope   (upslope_q),
		.valid_in  (c_v[ANGLE_ITERATIONS]),
		.vec_in    (c_vec[ANGLE_ITERATIONS]),
		.go        (c_go[ANGLE_ITERATIONS]),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.aspect    (aspect),
		.undefined (undefined)
	);

endmodule

### src/tasp_checker.sv
// port-level checks of the terrain aspect block and their bind
// depends on tasp_pkg and terrain_aspect_3x3_defines.svh
`include "terrain_aspect_3x3_defines.svh"

module tasp_checker import tasp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [ASPECT_W-1:0] aspect,
	input logic                undefined
);

	// a stalled result holds
	`TA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(aspect) && $stable(undefined), "stalled result changed")

	// aspect stays below a full turn
	`TA_ASSERT(a_aspect_range, out_valid |-> aspect < ASP_FULL[ASPECT_W-1:0], "aspect out of range")

	// flat window reports zero aspect
	`TA_ASSERT(a_flat_zero, out_valid && undefined |-> aspect == ASP_ZERO, "flat window with nonzero aspect")

	// input stalls only behind a full pipeline waiting on the receiver
	`TA_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without backpressure")

	// no result after a reset edge
	`TA_ASSERT_RST(a_reset_empty, !arst_n |=> !out_valid, "result during reset")

endmodule

bind terrain_aspect_3x3 tasp_checker u_checker (.*);
